@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tns_pkg.sv @@
`default_nettype none
package tns_pkg;

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_APPEND = 3'd1,
        FN_CLEAR  = 3'd2,
        FN_PLAY   = 3'd3,
        FN_BEEP   = 3'd4
    } t_func;

    localparam int FREQ_W = 15;
    localparam int DUR_W  = 16;
    localparam int DIV_W  = 16;
    localparam int NOTE_W = FREQ_W + DUR_W;
    localparam int OUT_CNT_W = 7;

    localparam logic [20:0]       TONE_CLK_HZ = 21'd1193180;
    localparam logic [DIV_W-1:0]  DIV_MAX     = 16'hFFFF;
    // below this the quotient exceeds 16 bits
    localparam logic [FREQ_W-1:0] SAT_FREQ_MIN =
        FREQ_W'(1193180 / 65536 + 1);
    localparam logic [FREQ_W-1:0] DIV_INIT_REM = FREQ_W'(TONE_CLK_HZ >> DIV_W);
    localparam logic [DIV_W-1:0]  DIVIDEND_LO  = DIV_W'(TONE_CLK_HZ);

    typedef struct packed {
        logic capture;
        logic tick;
        logic append;
        logic clear;
        logic play_rst;
        logic ram_rd;
        logic load;
        logic advance;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  timing;
        logic  expire;
        logic  have_next;
        logic  full;
        logic  empty;
        logic  load_freq_zero;
        logic  div_last;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ hw/rtl/tns_ram.sv @@
`default_nettype none
module tns_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tns_ctrl.sv @@
`default_nettype none
module tns_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    output logic                 o_valid,
    output tns_pkg::t_dp_cmd     o_cmd,
    input  wire tns_pkg::t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DIV
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                unique case (i_sts.func)
                    tns_pkg::FN_TICK: begin
                        if (i_sts.timing) begin
                            o_cmd.tick = 1'b1;
                            if (i_sts.expire && i_sts.have_next) begin
                                o_cmd.ram_rd = 1'b1;
                                n_state      = S_LOAD;
                                n_valid      = 1'b0;
                            end
                        end
                    end
                    tns_pkg::FN_APPEND: begin
                        o_cmd.append = !i_sts.full;
                    end
                    tns_pkg::FN_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    tns_pkg::FN_PLAY: begin
                        if (!i_sts.empty) begin
                            o_cmd.play_rst = 1'b1;
                            o_cmd.ram_rd   = 1'b1;
                            n_state        = S_LOAD;
                            n_valid        = 1'b0;
                        end
                    end
                    tns_pkg::FN_BEEP: begin
                        n_state = S_LOAD;
                        n_valid = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_LOAD: begin
                o_cmd.load    = 1'b1;
                o_cmd.advance = (i_sts.func != tns_pkg::FN_BEEP);
                if (i_sts.load_freq_zero) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule
`default_nettype wire

@@ hw/rtl/tns_dp.sv @@
`default_nettype none
module tns_dp #(
    parameter int NOTE_SLOTS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tns_pkg::t_dp_cmd                i_cmd,
    output tns_pkg::t_dp_sts                     o_sts,
    input  wire logic [2:0]                      i_func,
    input  wire logic [tns_pkg::FREQ_W-1:0]      i_frequency,
    input  wire logic [tns_pkg::DUR_W-1:0]       i_duration_ms,
    output logic                                 o_speaker_on,
    output logic [tns_pkg::DIV_W-1:0]            o_divisor,
    output logic                                 o_busy_res,
    output logic [tns_pkg::OUT_CNT_W-1:0]        o_next_note,
    output logic [tns_pkg::OUT_CNT_W-1:0]        o_stored_notes
);

    localparam int AW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int CW = $clog2(NOTE_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS = CW'(NOTE_SLOTS);

    // captured command beat
    tns_pkg::t_func              r_func;
    logic [tns_pkg::FREQ_W-1:0]  r_in_freq;
    logic [tns_pkg::DUR_W-1:0]   r_in_dur;

    logic [CW-1:0]               r_total;
    logic [CW-1:0]               r_play;
    logic [tns_pkg::DUR_W-1:0]   r_elapsed;
    logic [tns_pkg::DUR_W-1:0]   r_dur;
    logic [tns_pkg::FREQ_W-1:0]  r_freq;
    logic                        r_timing;
    logic                        r_gate;
    logic [tns_pkg::DIV_W-1:0]   r_divisor;

    // restoring divider, one quotient bit a cycle
    logic [tns_pkg::FREQ_W-1:0]  r_rem;
    logic [tns_pkg::DIV_W-1:0]   r_quo;
    logic [3:0]                  r_cnt;
    logic                        r_sat;

    logic [tns_pkg::NOTE_W-1:0]  ram_rd_data;
    logic [AW-1:0]               ram_rd_addr;
    logic [tns_pkg::DUR_W-1:0]   el_next;
    logic [tns_pkg::FREQ_W-1:0]  load_freq;
    logic [tns_pkg::DUR_W-1:0]   load_dur;
    logic [tns_pkg::FREQ_W:0]    trial;
    logic                        trial_ge;

    assign ram_rd_addr = i_cmd.play_rst ? '0 : r_play[AW-1:0];

    tns_ram #(
        .WIDTH (tns_pkg::NOTE_W),
        .DEPTH (NOTE_SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append),
        .i_wr_addr (r_total[AW-1:0]),
        .i_wr_data ({r_in_freq, r_in_dur}),
        .i_rd_en   (i_cmd.ram_rd),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign el_next = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;

    always_comb begin
        if (r_func == tns_pkg::FN_BEEP) begin
            load_freq = r_in_freq;
            load_dur  = r_in_dur;
        end else begin
            load_freq = ram_rd_data[tns_pkg::NOTE_W-1:tns_pkg::DUR_W];
            load_dur  = ram_rd_data[tns_pkg::DUR_W-1:0];
        end
    end

    assign trial    = {r_rem, tns_pkg::DIVIDEND_LO[r_cnt]};
    assign trial_ge = (trial >= {1'b0, r_freq});

    always_comb begin
        o_sts.func           = r_func;
        o_sts.timing         = r_timing;
        o_sts.expire         = (el_next >= r_dur);
        o_sts.have_next      = (r_play < r_total);
        o_sts.full           = (r_total == SLOTS);
        o_sts.empty          = (r_total == '0);
        o_sts.load_freq_zero = (load_freq == '0);
        o_sts.div_last       = (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= tns_pkg::t_func'(i_func);
            r_in_freq <= i_frequency;
            r_in_dur  <= i_duration_ms;
        end
        if (i_cmd.load) begin
            r_rem <= tns_pkg::DIV_INIT_REM;
            r_quo <= '0;
            r_cnt <= 4'hF;
            r_sat <= (load_freq < tns_pkg::SAT_FREQ_MIN);
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? tns_pkg::FREQ_W'(trial - {1'b0, r_freq})
                              : trial[tns_pkg::FREQ_W-1:0];
            r_quo <= {r_quo[tns_pkg::DIV_W-2:0], trial_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_play    <= '0;
            r_elapsed <= '0;
            r_dur     <= '0;
            r_freq    <= '0;
            r_timing  <= 1'b0;
            r_gate    <= 1'b0;
            r_divisor <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_elapsed <= el_next;
                if (el_next >= r_dur) begin
                    r_gate   <= 1'b0;
                    r_timing <= 1'b0;
                end
            end
            if (i_cmd.append) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.clear) begin
                r_total <= '0;
                r_play  <= '0;
            end
            if (i_cmd.play_rst) begin
                r_play <= '0;
            end
            if (i_cmd.load) begin
                r_elapsed <= '0;
                r_dur     <= load_dur;
                r_freq    <= load_freq;
                r_timing  <= 1'b1;
                if (load_freq == '0) begin
                    r_gate <= 1'b0;
                end
                if (i_cmd.advance) begin
                    r_play <= r_play + 1'b1;
                end
            end
            if (i_cmd.div_step && (r_cnt == '0)) begin
                r_divisor <= r_sat ? tns_pkg::DIV_MAX
                                   : {r_quo[tns_pkg::DIV_W-2:0], trial_ge};
                r_gate    <= 1'b1;
            end
        end
    end

    assign o_speaker_on   = r_gate;
    assign o_divisor      = r_divisor;
    assign o_busy_res     = r_timing;
    assign o_next_note    = tns_pkg::OUT_CNT_W'(r_play);
    assign o_stored_notes = tns_pkg::OUT_CNT_W'(r_total);

endmodule
`default_nettype wire

@@ hw/rtl/tone_note_sequencer.sv @@
`default_nettype none
// Speaker tone sequencer. One command beat is taken when start is high and busy low;
// exactly one result beat follows, shown for a single cycle with o_valid, and it must
// be taken then since the block cannot be held off. Append, clear and any tick or other
// command that loads no note give their result from the execute state, and busy clears
// in the result cycle. A command that starts a tone (beep, play, or a tick whose note
// expires with stored notes left) holds busy through execute, load and divide states:
// the divisor 1193180 / frequency comes from a restoring divider producing one quotient
// bit per cycle. A pause holds busy through the execute and load states. The note
// store is a single RAM with registered read, one access to read a note before it starts.
`include "assert_macros.svh"
module tone_note_sequencer #(
    parameter int NOTE_SLOTS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [2:0]                 i_func,
    input  wire logic [14:0]                i_frequency,
    input  wire logic [15:0]                i_duration_ms,
    output logic                            o_valid,
    output logic                            o_speaker_on,
    output logic [15:0]                     o_divisor,
    output logic                            o_busy_res,
    output logic [6:0]                      o_next_note,
    output logic [6:0]                      o_stored_notes
);

    tns_pkg::t_dp_cmd cmd;
    tns_pkg::t_dp_sts sts;

    tns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    tns_dp #(
        .NOTE_SLOTS (NOTE_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_frequency    (i_frequency),
        .i_duration_ms  (i_duration_ms),
        .o_speaker_on   (o_speaker_on),
        .o_divisor      (o_divisor),
        .o_busy_res     (o_busy_res),
        .o_next_note    (o_next_note),
        .o_stored_notes (o_stored_notes)
    );

    // result beat only once the command has fully finished
    `ASSERT_ALWAYS(a_valid_idle, i_clk, i_rst_n, !(o_valid && busy), "result while busy")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid,
        "accepted beat did not start work")
    `ASSERT_ALWAYS(a_gate_timing, i_clk, i_rst_n, !o_speaker_on || o_busy_res,
        "speaker on without a timing note")
    `ASSERT_ALWAYS(a_gate_div, i_clk, i_rst_n, !o_speaker_on || (o_divisor != 16'd0),
        "speaker on with zero divisor")

endmodule
`default_nettype wire
